// ===== hdl/pnbw_pkg.sv =====
// shared types, constants and face-centre tables for the normal binning block
`timescale 1ns / 1ps

package pnbw_pkg;

   localparam int IN_BITS   = 16;
   localparam int W_BITS    = 15;
   localparam int FACE_BITS = 5;
   localparam int TIDX_BITS = 6;
   localparam int KIND_BITS = 3;
   localparam int DOT_BITS  = 32;
   localparam int N2_BITS   = 32;
   localparam int SQ_BITS   = 64;
   localparam int Q_BITS    = 47;
   localparam int NUM_CENTRES = 50;

   // polyhedron selection codes
   localparam logic [KIND_BITS-1:0] KIND_TETRA = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CUBE  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_OCTA  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DODECA = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_ICOSA = 3'd4;

   typedef logic signed [IN_BITS-1:0] comp_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec_type;

   // payload of one face result as it walks the root stages
   typedef struct packed {
      logic [FACE_BITS-1:0] face;
      logic                 last;
      logic                 zero;
      logic [SQ_BITS-1:0]   d;
      logic [N2_BITS-1:0]   n2;
      logic [SQ_BITS-1:0]   p;
      logic [Q_BITS-1:0]    q;
      logic [W_BITS-1:0]    w;
   } root_type;

   // face centres, Q1.14
   localparam logic signed [15:0] CX [0:NUM_CENTRES-1] = '{
      0, 0, 13369, -13369,
      16384, -16384, 0, 0, 0, 0,
      13369, 13369, -13369, -13369, 0, 0, 0, 0,
      15368, 15368, -15368, -15368, 0, 0, 0, 0, 5669, -5669, 5669, -5669,
      16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384, 0, 0, 0, 0,
      14303, -14303, 14303, -14303, 2081, 2081, -2081, -2081};
   localparam logic signed [15:0] CY [0:NUM_CENTRES-1] = '{
      0, 15450, -7717, -7717,
      0, 0, 16384, -16384, 0, 0,
      0, 0, 0, 0, 13369, 13369, -13369, -13369,
      5669, -5669, 5669, -5669, 15368, 15368, -15368, -15368, 0, 0, 0, 0,
      16384, 16384, -16384, -16384, 16384, 16384, -16384, -16384,
      2081, 2081, -2081, -2081, 0, 0, 0, 0, 14303, -14303, 14303, -14303};
   localparam logic signed [15:0] CZ [0:NUM_CENTRES-1] = '{
      -16384, 5456, 5456, 5456,
      0, 0, 0, 0, 16384, -16384,
      9454, -9454, 9454, -9454, 9454, -9454, 9454, -9454,
      0, 0, 0, 0, 5669, -5669, 5669, -5669, 15368, 15368, -15368, -15368,
      16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384,
      14303, -14303, 14303, -14303, 2081, 2081, -2081, -2081, 0, 0, 0, 0};

   function automatic logic [FACE_BITS-1:0] face_count(input logic [KIND_BITS-1:0] kind);
      unique case (kind)
         KIND_TETRA:  face_count = 5'd4;
         KIND_CUBE:   face_count = 5'd6;
         KIND_OCTA:   face_count = 5'd8;
         KIND_DODECA: face_count = 5'd12;
         default:     face_count = 5'd20;
      endcase
   endfunction

   function automatic logic [TIDX_BITS-1:0] face_start(input logic [KIND_BITS-1:0] kind);
      unique case (kind)
         KIND_TETRA:  face_start = 6'd0;
         KIND_CUBE:   face_start = 6'd4;
         KIND_OCTA:   face_start = 6'd10;
         KIND_DODECA: face_start = 6'd18;
         default:     face_start = 6'd30;
      endcase
   endfunction

endpackage

// ===== hdl/pnbw_req_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps

interface pnbw_req_if;
   logic                    valid;
   logic                    ready;
   pnbw_pkg::comp_type      normal_x;
   pnbw_pkg::comp_type      normal_y;
   pnbw_pkg::comp_type      normal_z;
   modport source (output valid, normal_x, normal_y, normal_z, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface pnbw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pnbw_pkg::FACE_BITS-1:0]      face_index;
   logic [pnbw_pkg::W_BITS-1:0]         face_weight;
   logic                                last_face;
   modport source (output valid, face_index, face_weight, last_face, input ready);
   modport sink   (input valid, face_index, face_weight, last_face, output ready);
endinterface

// ===== hdl/polyhedral_normal_bin_weights.sv =====
// top level: face sequencer, front-end pipeline and bit-per-stage weight root
//
// channel   dir  handshake          payload
// req_chan  in   valid / ready      normal_x, normal_y, normal_z (signed 16)
// rsp_chan  out  valid / ready      face_index (5), face_weight (15), last_face
// csr       in   csr_wr_en          csr_wr_data (3) = polyhedron kind
//
// one face result leaves per cycle while rsp_chan is not stalled; a transaction yields 4, 6, 8, 12 or 20
// results, so a new vector is taken only as the last face of the current one issues,
// set by the face sequencer issuing one face per cycle unless the pipe is held
// the path from issue to rsp has 3 front-end stages plus 15 weight-bit stages
// reset is synchronous, clears all valid bits and sets the kind to icosahedron
// the whole pipe holds on a single enable when the rsp stage is full and not taken
`timescale 1ns / 1ps

module polyhedral_normal_bin_weights (
   input  logic                              clock,
   input  logic                              reset,
   pnbw_req_if.sink                          req_chan,
   pnbw_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [pnbw_pkg::KIND_BITS-1:0]    csr_wr_data
);

   localparam int NUM_BITS = pnbw_pkg::W_BITS;

   // polyhedron kind register
   logic [pnbw_pkg::KIND_BITS-1:0]  kind_ff;

   // face sequencer
   logic                            busy_ff, busy_in;
   pnbw_pkg::vec_type               vec_ff, vec_in;
   logic [pnbw_pkg::FACE_BITS-1:0]  face_ff, face_in;
   logic [pnbw_pkg::FACE_BITS-1:0]  count_ff, count_in;
   logic [pnbw_pkg::TIDX_BITS-1:0]  start_ff, start_in;
   logic                            en, issue, last_issue, req_take;
   logic [pnbw_pkg::TIDX_BITS-1:0]  tidx;

   // pipeline links, element 0 is the front-end output
   logic                            link_valid [0:NUM_BITS];
   pnbw_pkg::root_type              link_root  [0:NUM_BITS];

   // pipe moves unless the result stage holds an untaken transaction
   assign en         = !link_valid[NUM_BITS] || rsp_chan.ready;
   assign last_issue = (face_ff == (count_ff - 5'd1));
   assign issue      = busy_ff && en;
   assign req_chan.ready = !busy_ff || (en && last_issue);
   assign req_take   = req_chan.valid && req_chan.ready;
   assign tidx       = start_ff + {1'b0, face_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= pnbw_pkg::KIND_ICOSA;
      end else if (csr_wr_en) begin
         kind_ff <= csr_wr_data;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      vec_in   = vec_ff;
      face_in  = face_ff;
      count_in = count_ff;
      start_in = start_ff;
      if (issue) begin
         face_in = face_ff + 5'd1;
         if (last_issue) begin
            busy_in = 1'b0;
         end
      end
      if (req_take) begin
         busy_in    = 1'b1;
         vec_in.x   = req_chan.normal_x;
         vec_in.y   = req_chan.normal_y;
         vec_in.z   = req_chan.normal_z;
         face_in    = '0;
         count_in   = pnbw_pkg::face_count(kind_ff);
         start_in   = pnbw_pkg::face_start(kind_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff   <= vec_in;
      face_ff  <= face_in;
      count_ff <= count_in;
      start_ff <= start_in;
   end

   // products, sums and squared dot
   pnbw_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (issue),
      .vec_in    (vec_ff),
      .tidx_in   (tidx),
      .face_in   (face_ff),
      .last_in   (last_issue),
      .valid_out (link_valid[0]),
      .root_out  (link_root[0])
   );

   // weight bits from the top down, one stage each
   for (genvar g = 0; g < NUM_BITS; g++) begin : g_bit
      pnbw_bit #(
         .BIT (NUM_BITS - 1 - g)
      ) u_bit (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (link_valid[g]),
         .root_in   (link_root[g]),
         .valid_out (link_valid[g+1]),
         .root_out  (link_root[g+1])
      );
   end

   // last root stage doubles as the output register
   assign rsp_chan.valid       = link_valid[NUM_BITS];
   assign rsp_chan.face_index  = link_root[NUM_BITS].face;
   assign rsp_chan.face_weight = link_root[NUM_BITS].w;
   assign rsp_chan.last_face   = link_root[NUM_BITS].last;

   // sequencer never runs past the face count
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (face_ff < count_ff))
      else $error("face counter beyond face count");

   // an accepted transaction starts at face zero
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (busy_ff && (face_ff == '0)))
      else $error("sequencer did not start a new vector");

   // a held pipe keeps the result stage unchanged
   assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(link_root[NUM_BITS]) && link_valid[NUM_BITS]))
      else $error("result stage changed during stall");

endmodule

// ===== hdl/pnbw_dot.sv =====
// three-stage front end: products, dot and norm sums, squared dot
`timescale 1ns / 1ps

module pnbw_dot (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             valid_in,
   input  pnbw_pkg::vec_type                vec_in,
   input  logic [pnbw_pkg::TIDX_BITS-1:0]   tidx_in,
   input  logic [pnbw_pkg::FACE_BITS-1:0]   face_in,
   input  logic                             last_in,
   output logic                             valid_out,
   output pnbw_pkg::root_type               root_out
);

   // stage 1: per-axis products and squares
   logic                                s1_valid_ff;
   logic signed [31:0]                  px_ff, py_ff, pz_ff;
   logic signed [31:0]                  sx_ff, sy_ff, sz_ff;
   logic signed [31:0]                  px_in, py_in, pz_in, sx_in, sy_in, sz_in;
   logic [pnbw_pkg::FACE_BITS-1:0]      s1_face_ff, s2_face_ff, s3_face_ff;
   logic                                s1_last_ff, s2_last_ff, s3_last_ff;

   // stage 2: sums
   logic                                s2_valid_ff;
   logic signed [pnbw_pkg::DOT_BITS-1:0] dot_ff, dot_in;
   logic [pnbw_pkg::N2_BITS-1:0]        n2_ff, n2_in;

   // stage 3: squared dot
   logic                                s3_valid_ff;
   logic [pnbw_pkg::SQ_BITS-1:0]        d_ff, d_in;
   logic [pnbw_pkg::N2_BITS-1:0]        s3_n2_ff;
   logic                                zero_ff, zero_in;
   logic [61:0]                         d62;
   logic [30:0]                         dot_mag;

   always_comb begin
      px_in = vec_in.x * pnbw_pkg::CX[tidx_in];
      py_in = vec_in.y * pnbw_pkg::CY[tidx_in];
      pz_in = vec_in.z * pnbw_pkg::CZ[tidx_in];
      sx_in = vec_in.x * vec_in.x;
      sy_in = vec_in.y * vec_in.y;
      sz_in = vec_in.z * vec_in.z;
   end

   always_comb begin
      dot_in = px_ff + py_ff + pz_ff;
      n2_in  = $unsigned(sx_ff) + $unsigned(sy_ff) + $unsigned(sz_ff);
   end

   always_comb begin
      dot_mag = dot_ff[30:0];
      d62     = dot_mag * dot_mag;
      d_in    = {2'b00, d62};
      // not positive, or zero vector: weight zero
      zero_in = dot_ff[31] || (dot_ff == '0) || (n2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
         s1_face_ff <= face_in;
         s1_last_ff <= last_in;
         dot_ff <= dot_in;
         n2_ff <= n2_in;
         s2_face_ff <= s1_face_ff;
         s2_last_ff <= s1_last_ff;
         d_ff <= d_in;
         zero_ff <= zero_in;
         s3_n2_ff <= n2_ff;
         s3_face_ff <= s2_face_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   always_comb begin
      valid_out     = s3_valid_ff;
      root_out.face = s3_face_ff;
      root_out.last = s3_last_ff;
      root_out.zero = zero_ff;
      root_out.d    = d_ff;
      root_out.n2   = s3_n2_ff;
      root_out.p    = '0;
      root_out.q    = '0;
      root_out.w    = '0;
   end

endmodule

// ===== hdl/pnbw_bit.sv =====
// one weight bit: trial (w+2^k)^2*n2 against dot^2, built from running sums
`timescale 1ns / 1ps

module pnbw_bit #(
   parameter int BIT = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  pnbw_pkg::root_type  root_in,
   output logic                valid_out,
   output pnbw_pkg::root_type  root_out
);

   logic                               valid_ff;
   pnbw_pkg::root_type                 root_ff, root_in_next;
   logic [pnbw_pkg::SQ_BITS-1:0]       trial;
   logic [pnbw_pkg::Q_BITS-1:0]        q_trial;
   logic                               fits;

   always_comb begin
      // p = w^2*n2, q = w*n2
      trial = root_in.p
            + ({{(pnbw_pkg::SQ_BITS-pnbw_pkg::Q_BITS){1'b0}}, root_in.q} << (BIT + 1))
            + ({{(pnbw_pkg::SQ_BITS-pnbw_pkg::N2_BITS){1'b0}}, root_in.n2} << (2 * BIT));
      q_trial = root_in.q
              + ({{(pnbw_pkg::Q_BITS-pnbw_pkg::N2_BITS){1'b0}}, root_in.n2} << BIT);
      fits = !root_in.zero && (trial <= root_in.d);
      root_in_next = root_in;
      if (fits) begin
         root_in_next.p      = trial;
         root_in_next.q      = q_trial;
         root_in_next.w[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign root_out  = root_ff;

endmodule
